/* sv/weighted_channel_beamformer_core_defines.svh */
// Assertion macros shared by the beamformer RTL.
// Included by files that check their own logic; depends on nothing else.
`ifndef WEIGHTED_CHANNEL_BEAMFORMER_CORE_DEFINES_SVH
`define WEIGHTED_CHANNEL_BEAMFORMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define WCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wcb: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define WCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wcb: next-cycle check failed");
`else
`define WCB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WCB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/wcb_pkg.sv */
// Shared widths, codes and types for the weighted channel beamformer.
// No dependencies; used by the interfaces, the lane and the top level.
package wcb_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int WEIGHT_W   = 16;
  localparam int Q23_W      = 24;
  localparam int PROD_W     = Q23_W + WEIGHT_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int CC_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int NUM_FIELDS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Largest float32 magnitude pattern accepted (1.0)
  localparam logic [SAMPLE_W-2:0] F32_ONE_MAG = 31'h3F80_0000;
  localparam logic [7:0]          F32_BIAS    = 8'd127;

  localparam logic signed [Q23_W-1:0] Q23_MAX = 24'sh7F_FFFF;
  localparam logic signed [Q23_W-1:0] Q23_MIN = 24'sh80_0000;
  localparam logic signed [SUM_W-1:0] ONE_Q35 = 42'sh008_0000_0000;
  localparam logic signed [SUM_W-1:0] NEG_ONE_Q35 = -ONE_Q35;
  localparam logic [36:0]             Q35_HALF_LSB = 37'd2048;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SAMPLE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE      = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_3      = 3'd4;

  localparam logic [CC_W-1:0]            CC_RESET       = 3'd4;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_0_RESET = 16'sd4096;

  // Stage advance strobes handed to each lane
  typedef struct packed {
    logic s1;
    logic s2;
  } lane_adv_t;

endpackage

/* sv/wcb_if.sv */
// Input frame and result channel interfaces of the beamformer.
// Depends on wcb_pkg for field widths.
interface wcb_in_if;
  logic                          valid;
  logic                          ready;
  logic [wcb_pkg::SAMPLE_W-1:0]  sample_0;
  logic [wcb_pkg::SAMPLE_W-1:0]  sample_1;
  logic [wcb_pkg::SAMPLE_W-1:0]  sample_2;
  logic [wcb_pkg::SAMPLE_W-1:0]  sample_3;
  logic                          last_in_message;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, last_in_message,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, last_in_message,
    output ready
  );
endinterface

interface wcb_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wcb_pkg::Q23_W-1:0]   beam_sample;
  logic [wcb_pkg::STATUS_W-1:0]       status;
  logic                               last_out;

  modport source (
    output valid, beam_sample, status, last_out,
    input  ready
  );
  modport sink (
    input  valid, beam_sample, status, last_out,
    output ready
  );
endinterface

/* sv/wcb_lane.sv */
// One channel lane: float32 check and Q1.23 conversion, then weight multiply.
// Two register stages advanced by the top level; depends on wcb_pkg.
module wcb_lane (
  input  logic                                 clk,
  input  wcb_pkg::lane_adv_t                   adv,
  input  logic [wcb_pkg::SAMPLE_W-1:0]         sample,
  input  logic                                 in_use,
  input  logic signed [wcb_pkg::WEIGHT_W-1:0]  weight,
  output logic                                 bad_r,
  output logic signed [wcb_pkg::PROD_W-1:0]    prod_r
);

  localparam int Q23_MANT_W = wcb_pkg::Q23_W;

  logic [wcb_pkg::SAMPLE_W-2:0]        mag_bits;
  logic [7:0]                          exp_bits;
  logic [7:0]                          shift;
  logic [Q23_MANT_W-1:0]               mant;
  logic [Q23_MANT_W:0]                 scaled;
  logic [Q23_MANT_W+1:0]               rounded;
  logic [Q23_MANT_W:0]                 mag_q23;
  logic [Q23_MANT_W:0]                 neg_q23;
  logic                                ok;
  logic                                keep;
  logic signed [wcb_pkg::Q23_W-1:0]    q23_nxt;
  logic signed [wcb_pkg::Q23_W-1:0]    q23_r;
  logic                                bad_nxt;
  logic signed [wcb_pkg::PROD_W-1:0]   prod_nxt;

  // Check range and convert to Q1.23, rounding half away from zero
  always_comb begin
    mag_bits = sample[wcb_pkg::SAMPLE_W-2:0];
    exp_bits = mag_bits[30:23];
    ok       = (mag_bits <= wcb_pkg::F32_ONE_MAG);
    keep     = in_use && ok;
    bad_nxt  = in_use && !ok;
    mant     = {(exp_bits != 8'd0), mag_bits[22:0]};
    shift    = wcb_pkg::F32_BIAS - exp_bits;
    scaled   = {mant, 1'b0} >> shift;
    rounded  = ({1'b0, scaled} + (Q23_MANT_W+2)'(1)) >> 1;
    mag_q23  = rounded[Q23_MANT_W:0];
    neg_q23  = -mag_q23;
    if (!keep) begin
      q23_nxt = '0;
    end else if (sample[wcb_pkg::SAMPLE_W-1]) begin
      q23_nxt = neg_q23[Q23_MANT_W-1:0];
    end else if (mag_q23 > (Q23_MANT_W+1)'(wcb_pkg::Q23_MAX)) begin
      q23_nxt = wcb_pkg::Q23_MAX;
    end else begin
      q23_nxt = mag_q23[Q23_MANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      q23_r <= q23_nxt;
      bad_r <= bad_nxt;
    end
  end

  // Weight the converted sample; unused or bad lanes carry zero
  assign prod_nxt = q23_r * weight;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

/* sv/weighted_channel_beamformer_core.sv */
// Channel  | Direction | Payload
// in_ch    | sink      | sample_0..sample_3 (float32 bits), last_in_message
// out_ch   | source    | beam_sample (Q1.23), status, last_out
// cfg_*    | write     | channel_count, weight_0..weight_3 (Q4.12)
//
// One frame per cycle while the sink takes results; a frame passes through the
// convert, multiply, sum and round/saturate register stages before its result is offered.
// Reset clears the stage valid bits and loads the configuration register defaults.
// Ready walks back stage by stage: an empty stage keeps taking transactions
// while the output register holds a result the sink has not taken.
// Depends on wcb_pkg, wcb_if, wcb_lane and the assertion macro header.
`include "weighted_channel_beamformer_core_defines.svh"

module weighted_channel_beamformer_core #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wcb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wcb_pkg::CFG_DATA_W-1:0]      cfg_data,
  wcb_in_if.sink                              in_ch,
  wcb_out_if.source                           out_ch
);

  localparam int LANES = (MAX_CHANNELS < wcb_pkg::NUM_FIELDS) ?
                         MAX_CHANNELS : wcb_pkg::NUM_FIELDS;

  logic [wcb_pkg::CC_W-1:0]               channel_count_r;
  logic signed [wcb_pkg::WEIGHT_W-1:0]    weight_r [LANES];
  logic [wcb_pkg::CC_W-1:0]               n_eff;
  logic [wcb_pkg::SAMPLE_W-1:0]           in_sample [wcb_pkg::NUM_FIELDS];

  logic                                   en1, en2, en3, en4;
  wcb_pkg::lane_adv_t                     lane_adv;
  logic                                   v1_r, v2_r, v3_r, out_valid_r;
  logic                                   last1_r, last2_r, last3_r, last_out_r;
  logic                                   bad2_r, bad3_r;
  logic [LANES-1:0]                       lane_bad;
  logic signed [wcb_pkg::PROD_W-1:0]      lane_prod [LANES];
  logic signed [wcb_pkg::SUM_W-1:0]       sum_nxt;
  logic signed [wcb_pkg::SUM_W-1:0]       sum_r;

  logic                                   sum_neg;
  logic signed [wcb_pkg::SUM_W-1:0]       sum_abs;
  logic [36:0]                            round_sum;
  logic [wcb_pkg::Q23_W:0]                round_mag;
  logic [wcb_pkg::Q23_W:0]                round_neg;
  logic signed [wcb_pkg::Q23_W-1:0]       beam_nxt;
  logic [wcb_pkg::STATUS_W-1:0]           status_nxt;
  logic signed [wcb_pkg::Q23_W-1:0]       beam_r;
  logic [wcb_pkg::STATUS_W-1:0]           status_r;

  // Write configuration registers; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= wcb_pkg::CC_RESET;
      for (int i = 0; i < LANES; i++) begin
        weight_r[i] <= (i == 0) ? wcb_pkg::WEIGHT_0_RESET : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == wcb_pkg::CFG_CHANNEL_COUNT) begin
        channel_count_r <= cfg_data[wcb_pkg::CC_W-1:0];
      end
      for (int i = 0; i < LANES; i++) begin
        if (cfg_index == wcb_pkg::CFG_WEIGHT_0 + wcb_pkg::CFG_IDX_W'(i)) begin
          weight_r[i] <= cfg_data[wcb_pkg::WEIGHT_W-1:0];
        end
      end
    end
  end

  // Clamp channel count to [1, LANES]
  always_comb begin
    if (channel_count_r == '0) begin
      n_eff = wcb_pkg::CC_W'(1);
    end else if (channel_count_r > wcb_pkg::CC_W'(LANES)) begin
      n_eff = wcb_pkg::CC_W'(LANES);
    end else begin
      n_eff = channel_count_r;
    end
  end

  // Stage advance: a stage moves when it is empty or its successor moves
  assign en4         = !out_valid_r || out_ch.ready;
  assign en3         = !v3_r || en4;
  assign en2         = !v2_r || en3;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;
  assign lane_adv.s1 = en1;
  assign lane_adv.s2 = en2;

  always_comb begin
    in_sample[0] = in_ch.sample_0;
    in_sample[1] = in_ch.sample_1;
    in_sample[2] = in_ch.sample_2;
    in_sample[3] = in_ch.sample_3;
  end

  // Conversion and multiply lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    wcb_lane u_lane (
      .clk    (clk),
      .adv    (lane_adv),
      .sample (in_sample[g]),
      .in_use (wcb_pkg::CC_W'(g) < n_eff),
      .weight (weight_r[g]),
      .bad_r  (lane_bad[g]),
      .prod_r (lane_prod[g])
    );
  end

  // Advance valid bits through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) out_valid_r <= v3_r;
    end
  end

  // Carry framing and error flags alongside the data
  always_ff @(posedge clk) begin
    if (en1) last1_r <= in_ch.last_in_message;
    if (en2) begin
      last2_r <= last1_r;
      bad2_r  <= |lane_bad;
    end
    if (en3) begin
      last3_r <= last2_r;
      bad3_r  <= bad2_r;
      sum_r   <= sum_nxt;
    end
  end

  // Sum the lane products exactly
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_nxt = sum_nxt + wcb_pkg::SUM_W'(lane_prod[i]);
    end
  end

  // Bad-sample and range checks, then round Q7.35 to Q1.23 half away from zero
  always_comb begin
    sum_neg   = sum_r[wcb_pkg::SUM_W-1];
    sum_abs   = sum_neg ? -sum_r : sum_r;
    round_sum = sum_abs[36:0] + wcb_pkg::Q35_HALF_LSB;
    round_mag = round_sum[36:12];
    round_neg = -round_mag;
    if (bad3_r) begin
      status_nxt = wcb_pkg::STATUS_BAD_SAMPLE;
      beam_nxt   = '0;
    end else if (sum_r > wcb_pkg::ONE_Q35) begin
      status_nxt = wcb_pkg::STATUS_RANGE;
      beam_nxt   = wcb_pkg::Q23_MAX;
    end else if (sum_r < wcb_pkg::NEG_ONE_Q35) begin
      status_nxt = wcb_pkg::STATUS_RANGE;
      beam_nxt   = wcb_pkg::Q23_MIN;
    end else if (sum_neg) begin
      status_nxt = wcb_pkg::STATUS_OK;
      beam_nxt   = round_neg[wcb_pkg::Q23_W-1:0];
    end else if (round_mag > (wcb_pkg::Q23_W+1)'(wcb_pkg::Q23_MAX)) begin
      status_nxt = wcb_pkg::STATUS_OK;
      beam_nxt   = wcb_pkg::Q23_MAX;
    end else begin
      status_nxt = wcb_pkg::STATUS_OK;
      beam_nxt   = round_mag[wcb_pkg::Q23_W-1:0];
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (en4) begin
      beam_r     <= beam_nxt;
      status_r   <= status_nxt;
      last_out_r <= last3_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.beam_sample = beam_r;
  assign out_ch.status      = status_r;
  assign out_ch.last_out    = last_out_r;

  `WCB_ASSERT_IMP(a_bad_gives_zero, clk, rst_n,
    out_valid_r && (status_r == wcb_pkg::STATUS_BAD_SAMPLE), beam_r == '0)
  `WCB_ASSERT_IMP(a_range_saturates, clk, rst_n,
    out_valid_r && (status_r == wcb_pkg::STATUS_RANGE),
    (beam_r == wcb_pkg::Q23_MAX) || (beam_r == wcb_pkg::Q23_MIN))
  `WCB_ASSERT_IMP(a_status_code, clk, rst_n, out_valid_r,
    (status_r == wcb_pkg::STATUS_OK) || (status_r == wcb_pkg::STATUS_BAD_SAMPLE) ||
    (status_r == wcb_pkg::STATUS_RANGE))
  `WCB_ASSERT_NXT(a_sum_holds_on_stall, clk, rst_n, v3_r && !en3,
    v3_r && $stable(sum_r) && $stable(bad3_r))

endmodule
